// ----- rtl/core/vnld_pkg.sv -----
// ----------------------------------------------------------------------------
// vnld_pkg
// Shared types and constants of the three-component vector unit.
// ----------------------------------------------------------------------------
package vnld_pkg;

  typedef enum logic [1:0] {
    CMD_DOT  = 2'd0,
    CMD_LEN  = 2'd1,
    CMD_NORM = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  localparam int NORM_STAGES = 5;
  localparam int ROOT_STAGES = 32;

  localparam logic [31:0] UNIT_POS_MAX = 32'd131071;
  localparam logic [31:0] UNIT_NEG_MAX = 32'd131072;

  // Sideband that travels with a word along the pipeline.
  typedef struct packed {
    cmd_t             cmd;
    logic [31:0]      scal;
    logic             ssat;
    logic             szero;
    logic [4:0]       k;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
  } tag_t;

endpackage

// ----- rtl/core/vnld_lane.sv -----
// ----------------------------------------------------------------------------
// vnld_lane
// One component lane: the product a*b and the square of |a|, registered.
// ----------------------------------------------------------------------------
module vnld_lane import vnld_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod_r,
  output logic        [63:0] sq_r,
  output logic        [31:0] mag_r,
  output logic               neg_r
);

  logic [31:0] mag_nxt;

  assign mag_nxt = a[31] ? 32'(-a) : 32'(a);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 64'(a) * 64'(b);
      sq_r   <= 64'(mag_nxt) * 64'(mag_nxt);
      mag_r  <= mag_nxt;
      neg_r  <= a[31];
    end
  end

endmodule

// ----- rtl/core/vnld_sqrt.sv -----
// ----------------------------------------------------------------------------
// vnld_sqrt
// Pipelined integer square root, one result bit per stage, with remainder.
// ----------------------------------------------------------------------------
module vnld_sqrt import vnld_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root,
  output logic [63:0] rem
);

  logic [63:0] n_r   [ROOT_STAGES];
  logic [63:0] res_r [ROOT_STAGES];

  for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_stage
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * g);
    logic [63:0] n_in;
    logic [63:0] res_in;
    logic [64:0] trial;

    if (g == 0) begin : g_first
      assign n_in   = rad;
      assign res_in = '0;
    end else begin : g_rest
      assign n_in   = n_r[g-1];
      assign res_in = res_r[g-1];
    end

    assign trial = {1'b0, res_in} + {1'b0, BIT};

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, n_in} >= trial) begin
          n_r[g]   <= n_in - trial[63:0];
          res_r[g] <= (res_in >> 1) + BIT;
        end else begin
          n_r[g]   <= n_in;
          res_r[g] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res_r[ROOT_STAGES-1][31:0];
  assign rem  = n_r[ROOT_STAGES-1];

endmodule

// ----- rtl/core/vnld_div.sv -----
// ----------------------------------------------------------------------------
// vnld_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vnld_div import vnld_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [FRAC_BITS+33:0] dvd,
  input  logic [31:0]           dsr,
  output logic [FRAC_BITS+1:0]  quo
);

  localparam int DW = FRAC_BITS + 34;
  localparam int QB = FRAC_BITS + 2;

  logic [DW-1:0] rem_r [QB];
  logic [QB-1:0] q_r   [QB];
  logic [31:0]   dsr_r [QB];

  for (genvar g = 0; g < QB; g++) begin : g_stage
    localparam int J = QB - 1 - g;
    logic [DW-1:0] rem_in;
    logic [QB-1:0] q_in;
    logic [31:0]   dsr_in;
    logic [DW-1:0] dsh;
    logic [DW:0]   diff;

    if (g == 0) begin : g_first
      assign rem_in = dvd;
      assign q_in   = '0;
      assign dsr_in = dsr;
    end else begin : g_rest
      assign rem_in = rem_r[g-1];
      assign q_in   = q_r[g-1];
      assign dsr_in = dsr_r[g-1];
    end

    assign dsh  = DW'(dsr_in) << J;
    assign diff = {1'b0, rem_in} - {1'b0, dsh};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= diff[DW] ? rem_in : diff[DW-1:0];
        q_r[g]   <= {q_in[QB-2:0], ~diff[DW]};
        dsr_r[g] <= dsr_in;
      end
    end
  end

  assign quo = q_r[QB-1];

endmodule

// ----- rtl/core/vec3_normalize_length_dot.sv -----
// ----------------------------------------------------------------------------
// vec3_normalize_length_dot
// Fixed-point vector unit: dot product, length and normalisation of 3-vectors.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake            Contents
//   in_      input      in_valid/in_stall    cmd, vector a, vector b
//   out_     output     out_valid/out_stall  scalar, unit vector, status
//
// One word is taken every cycle unless the output stalls; the pipeline depth is
// set by the 32-stage square root and the FRAC_BITS + 2 stage dividers.
// The whole pipeline holds while a result word is stalled at the output.
// Reset clears the valid bits only; there is no clearing pass.
module vec3_normalize_length_dot import vnld_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_ax,
  input  logic signed [31:0] in_ay,
  input  logic signed [31:0] in_az,
  input  logic signed [31:0] in_bx,
  input  logic signed [31:0] in_by_comp,
  input  logic signed [31:0] in_bz,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_scalar_out,
  output logic signed [17:0] out_unit_x,
  output logic signed [17:0] out_unit_y,
  output logic signed [17:0] out_unit_z,
  output logic [1:0]         out_status
);

  localparam int DW = FRAC_BITS + 34;
  localparam int QB = FRAC_BITS + 2;

  logic en;

  // Lanes.
  logic signed [31:0] a_in [3];
  logic signed [31:0] b_in [3];
  logic signed [63:0] prod [3];
  logic        [63:0] sq   [3];
  logic        [31:0] mag  [3];
  logic               neg  [3];
  logic               v1_r;
  cmd_t               cmd1_r;

  assign a_in[0] = in_ax;
  assign a_in[1] = in_ay;
  assign a_in[2] = in_az;
  assign b_in[0] = in_bx;
  assign b_in[1] = in_by_comp;
  assign b_in[2] = in_bz;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    vnld_lane u_lane (
      .clk    (clk),
      .en     (en),
      .a      (a_in[l]),
      .b      (b_in[l]),
      .prod_r (prod[l]),
      .sq_r   (sq[l]),
      .mag_r  (mag[l]),
      .neg_r  (neg[l])
    );
  end

  // Merge stage.
  logic signed [65:0] dsum;
  logic signed [65:0] dsh;
  logic               dsat;
  logic [63:0]        ssum;
  tag_t               tag2_nxt;
  tag_t               tag2_r;
  logic [63:0]        s2_r;
  logic               v2_r;

  always_comb begin
    dsum = 66'(prod[0]) + 66'(prod[1]) + 66'(prod[2])
         + (66'sd1 <<< (FRAC_BITS - 1));
    dsh  = dsum >>> FRAC_BITS;
    dsat = (dsh > 66'sd2147483647) || (dsh < -66'sd2147483648);
    ssum = sq[0] + sq[1] + sq[2];
    tag2_nxt.cmd   = cmd1_r;
    tag2_nxt.scal  = dsat ? (dsh[65] ? 32'h8000_0000 : 32'h7FFF_FFFF) : dsh[31:0];
    tag2_nxt.ssat  = dsat;
    tag2_nxt.szero = (ssum == '0);
    tag2_nxt.k     = '0;
    for (int l = 0; l < 3; l++) begin
      tag2_nxt.mag[l] = mag[l];
      tag2_nxt.neg[l] = neg[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r <= cmd_t'(in_cmd);
      tag2_r <= tag2_nxt;
      s2_r   <= ssum;
    end
  end

  // Normalising shift, in even steps, only under normalise.
  logic [63:0] t_r    [NORM_STAGES];
  tag_t        tagn_r [NORM_STAGES];
  logic        vn_r   [NORM_STAGES];

  for (genvar g = 0; g < NORM_STAGES; g++) begin : g_norm
    localparam int SA = 32 >> g;
    logic [63:0] t_in;
    tag_t        tag_in;
    logic [63:0] t_nxt;
    tag_t        tag_nxt;

    if (g == 0) begin : g_first
      assign t_in   = s2_r;
      assign tag_in = tag2_r;
    end else begin : g_rest
      assign t_in   = t_r[g-1];
      assign tag_in = tagn_r[g-1];
    end

    always_comb begin
      t_nxt   = t_in;
      tag_nxt = tag_in;
      if (tag_in.cmd == CMD_NORM && t_in[63 -: SA] == '0) begin
        t_nxt     = t_in << SA;
        tag_nxt.k = tag_in.k + 5'(SA / 2);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        t_r[g]    <= t_nxt;
        tagn_r[g] <= tag_nxt;
      end
    end
  end

  // Square root.
  logic [31:0] root;
  logic [63:0] rrem;
  tag_t        tq_r [ROOT_STAGES];
  logic        vq_r [ROOT_STAGES];

  vnld_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (t_r[NORM_STAGES-1]),
    .root (root),
    .rem  (rrem)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      tq_r[0] <= tagn_r[NORM_STAGES-1];
      for (int i = 1; i < ROOT_STAGES; i++) begin
        tq_r[i] <= tq_r[i-1];
      end
    end
  end

  // Length rounding and divider set-up.
  tag_t          tq;
  tag_t          tp_nxt;
  tag_t          tp_r;
  logic          vp_r;
  logic [32:0]   len;
  logic          lsat;
  logic [5:0]    shamt;
  logic [DW-1:0] dvd_nxt [3];
  logic [DW-1:0] dvd_r   [3];
  logic [31:0]   rdiv_r;

  always_comb begin
    tq     = tq_r[ROOT_STAGES-1];
    len    = {1'b0, root} + 33'(rrem > 64'(root));
    lsat   = (len[32:31] != 2'b00);
    shamt  = 6'(tq.k) + 6'(FRAC_BITS);
    tp_nxt = tq;
    case (tq.cmd)
      CMD_DOT: begin
      end
      CMD_LEN: begin
        tp_nxt.scal = lsat ? 32'h7FFF_FFFF : len[31:0];
        tp_nxt.ssat = lsat;
      end
      default: begin
        tp_nxt.scal = '0;
        tp_nxt.ssat = 1'b0;
      end
    endcase
    for (int l = 0; l < 3; l++) begin
      dvd_nxt[l] = DW'({tq.mag[l], 1'b0}) << shamt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tp_r   <= tp_nxt;
      rdiv_r <= root;
      for (int l = 0; l < 3; l++) begin
        dvd_r[l] <= dvd_nxt[l];
      end
    end
  end

  // Dividers.
  logic [QB-1:0] quo  [3];
  tag_t          td_r [QB];
  logic          vd_r [QB];

  for (genvar l = 0; l < 3; l++) begin : g_div
    vnld_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (en),
      .dvd (dvd_r[l]),
      .dsr (rdiv_r),
      .quo (quo[l])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      td_r[0] <= tp_r;
      for (int i = 1; i < QB; i++) begin
        td_r[i] <= td_r[i-1];
      end
    end
  end

  // Output stage.
  tag_t                td;
  logic [31:0]         qq;
  logic [31:0]         one;
  logic signed [17:0]  unit_nxt [3];
  logic                usat;
  logic signed [31:0]  scalar_nxt;
  logic [1:0]          status_nxt;
  logic signed [31:0]  scalar_r;
  logic signed [17:0]  unit_r [3];
  logic [1:0]          status_r;
  logic                out_valid_r;

  always_comb begin
    td   = td_r[QB-1];
    one  = 32'd1 << FRAC_BITS;
    usat = 1'b0;
    for (int l = 0; l < 3; l++) begin
      qq = (32'(quo[l]) + 32'd1) >> 1;
      if (qq > one) begin
        qq = one;
      end
      if (td.neg[l]) begin
        if (qq > UNIT_NEG_MAX) begin
          qq   = UNIT_NEG_MAX;
          usat = 1'b1;
        end
        unit_nxt[l] = -18'(qq);
      end else begin
        if (qq > UNIT_POS_MAX) begin
          qq   = UNIT_POS_MAX;
          usat = 1'b1;
        end
        unit_nxt[l] = 18'(qq);
      end
    end
    scalar_nxt = td.scal;
    status_nxt = td.ssat ? ST_SAT : ST_OK;
    if (td.cmd != CMD_NORM) begin
      for (int l = 0; l < 3; l++) begin
        unit_nxt[l] = '0;
      end
    end else if (td.szero) begin
      for (int l = 0; l < 3; l++) begin
        unit_nxt[l] = '0;
      end
      status_nxt = ST_ZERO;
    end else if (usat) begin
      status_nxt = ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scalar_r <= scalar_nxt;
      status_r <= status_nxt;
      for (int l = 0; l < 3; l++) begin
        unit_r[l] <= unit_nxt[l];
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      vp_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NORM_STAGES; i++) begin
        vn_r[i] <= 1'b0;
      end
      for (int i = 0; i < ROOT_STAGES; i++) begin
        vq_r[i] <= 1'b0;
      end
      for (int i = 0; i < QB; i++) begin
        vd_r[i] <= 1'b0;
      end
    end else if (en) begin
      v1_r    <= in_valid;
      v2_r    <= v1_r;
      vn_r[0] <= v2_r;
      for (int i = 1; i < NORM_STAGES; i++) begin
        vn_r[i] <= vn_r[i-1];
      end
      vq_r[0] <= vn_r[NORM_STAGES-1];
      for (int i = 1; i < ROOT_STAGES; i++) begin
        vq_r[i] <= vq_r[i-1];
      end
      vp_r    <= vq_r[ROOT_STAGES-1];
      vd_r[0] <= vp_r;
      for (int i = 1; i < QB; i++) begin
        vd_r[i] <= vd_r[i-1];
      end
      out_valid_r <= vd_r[QB-1];
    end
  end

  assign en             = !(out_valid_r && out_stall);
  assign in_stall       = !en;
  assign out_valid      = out_valid_r;
  assign out_scalar_out = scalar_r;
  assign out_unit_x     = unit_r[0];
  assign out_unit_y     = unit_r[1];
  assign out_unit_z     = unit_r[2];
  assign out_status     = status_r;

endmodule

// ----- rtl/core/vnld_chk.sv -----
// ----------------------------------------------------------------------------
// vnld_chk
// Port-level checks on the vector unit, bound to its top level.
// ----------------------------------------------------------------------------
module vnld_chk import vnld_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_scalar_out,
  input logic signed [17:0] out_unit_x,
  input logic signed [17:0] out_unit_y,
  input logic signed [17:0] out_unit_z,
  input logic [1:0]         out_status
);

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_scalar_out)
      && $stable(out_unit_x) && $stable(out_unit_y) && $stable(out_unit_z)
      && $stable(out_status))
    else $error("stalled result word changed");

  // The input is held back only by a stalled result.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // A zero-length normalisation gives all zeros.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ZERO |-> out_scalar_out == 0
      && out_unit_x == 0 && out_unit_y == 0 && out_unit_z == 0)
    else $error("zero-length result not cleared");

  // A unit vector is never given together with a scalar.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_unit_x != 0 || out_unit_y != 0 || out_unit_z != 0)
      |-> out_scalar_out == 0)
    else $error("unit vector and scalar both present");

endmodule

bind vec3_normalize_length_dot vnld_chk u_vnld_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_scalar_out (out_scalar_out),
  .out_unit_x     (out_unit_x),
  .out_unit_y     (out_unit_y),
  .out_unit_z     (out_unit_z),
  .out_status     (out_status)
);
